[hdl/bba_pkg.sv]
// Shared constants, types and helper functions of the bitmap block allocator.
package bba_pkg;

  localparam int MAP_BITS  = 4096;
  localparam int WORD_BITS = 64;
  localparam int FUNC_W    = 2;
  localparam int BLK_W     = 12;
  localparam int IDX_W     = 12;

  localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BPOS_W    = $clog2(WORD_BITS);
  localparam int WORD_P    = 1 << BPOS_W;
  localparam int LAST_WORD = NUM_WORDS - 1;
  localparam int TAIL_BITS = MAP_BITS - LAST_WORD * WORD_BITS;

  localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] PAD_MASK  = WORD_ONES >> TAIL_BITS;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MARK = 2'd0,
    FUNC_FREE = 2'd1,
    FUNC_SEEK = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CLS_MARK = 2'd0,
    CLS_FREE = 2'd1,
    CLS_SEEK = 2'd2,
    CLS_NONE = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [BLK_W-1:0] blk;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] free_index;
    logic             found;
  } res_t;

  // Position of the most significant set bit, counted from the top of the word.
  function automatic logic [BPOS_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_P-1:0] x;
    logic [WORD_P-1:0] hi;
    logic [BPOS_W-1:0] pos;
    x   = WORD_P'(v) << (WORD_P - WORD_BITS);
    pos = '0;
    for (int s = BPOS_W - 1; s >= 0; s--) begin
      hi = ~({WORD_P{1'b1}} >> (1 << s));
      if ((x & hi) == '0) begin
        pos[s] = 1'b1;
        x      = x << (1 << s);
      end
    end
    return pos;
  endfunction

endpackage

[hdl/bba_front.sv]
// Front end: accepts requests, classifies them and buffers them in a short queue.
module bba_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [bba_pkg::FUNC_W-1:0] in_func,
  input  logic [bba_pkg::BLK_W-1:0] in_block_number,
  output logic                      cmd_vld,
  output bba_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);
  import bba_pkg::*;

  cmd_t       q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;
  logic       in_range;
  cmd_t       cls_cmd;

  assign in_range = (int'(in_block_number) < MAP_BITS);

  always_comb begin
    cls_cmd.blk = in_block_number;
    unique case (func_t'(in_func))
      FUNC_MARK: cls_cmd.cls = in_range ? CLS_MARK : CLS_NONE;
      FUNC_FREE: cls_cmd.cls = in_range ? CLS_FREE : CLS_NONE;
      FUNC_SEEK: cls_cmd.cls = CLS_SEEK;
      default:   cls_cmd.cls = CLS_NONE;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign cmd_vld = (cnt_r != 2'd0);
  assign cmd     = q_r[rptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = cmd_pop && cmd_vld;

  always_comb begin
    wptr_nxt = push_ok ? ~wptr_r : wptr_r;
    rptr_nxt = pop_ok ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wptr_r] <= cls_cmd;
    end
  end

endmodule

[hdl/bba_back.sv]
// Back end: usage map memory, mark/free/seek sequencer and result queue.
module bba_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_vld,
  input  bba_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [bba_pkg::IDX_W-1:0] out_free_index,
  output logic                      out_found
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MODIFY = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FIND   = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 vld_q_r;
  logic [WADDR_W-1:0]   raddr;
  logic                 mem_we;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] word_eff;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WADDR_W-1:0]   cur_r, cur_nxt;
  cls_t                 cls_r, cls_nxt;
  logic [BLK_W-1:0]     blk_r, blk_nxt;
  logic [WORD_BITS-1:0] fword_r, fword_nxt;
  logic [BPOS_W-1:0]    fpos;

  res_t                 res_q_r [2];
  logic                 res_wptr_r;
  logic                 res_rptr_r;
  logic [1:0]           res_cnt_r;
  logic                 res_push;
  logic                 res_pop;
  res_t                 res_data;

  function automatic logic [WORD_BITS-1:0] rdata_eff_fn(input logic v,
                                                        input logic [WORD_BITS-1:0] d);
    return v ? d : '0;
  endfunction

  assign word_eff = (vld_q_r ? rdata_r : '0) | ((cur_r == WADDR_W'(LAST_WORD)) ?
                                                PAD_MASK : '0);
  assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} <<
                    (BPOS_W'(WORD_BITS - 1) - BPOS_W'(blk_r % WORD_BITS));
  assign fpos     = first_set(fword_r);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cls_nxt   = cls_r;
    blk_nxt   = blk_r;
    fword_nxt = fword_r;
    cmd_pop   = 1'b0;
    raddr     = cur_r;
    mem_we    = 1'b0;
    wdata     = '0;
    res_push  = 1'b0;
    res_data  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_vld && res_cnt_r != 2'd2) begin
          cmd_pop = 1'b1;
          cls_nxt = cmd.cls;
          blk_nxt = cmd.blk;
          case (cmd.cls)
            CLS_MARK, CLS_FREE: begin
              raddr     = WADDR_W'(cmd.blk / WORD_BITS);
              cur_nxt   = raddr;
              state_nxt = ST_MODIFY;
            end
            CLS_SEEK: begin
              raddr     = '0;
              cur_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_MODIFY: begin
        mem_we    = 1'b1;
        wdata     = (cls_r == CLS_MARK) ? (rdata_eff_fn(vld_q_r, rdata_r) | bit_mask)
                                        : (rdata_eff_fn(vld_q_r, rdata_r) & ~bit_mask);
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        raddr = WADDR_W'(cur_r + 1'b1);
        if (word_eff != WORD_ONES) begin
          fword_nxt = ~word_eff;
          state_nxt = ST_FIND;
        end else if (cur_r == WADDR_W'(LAST_WORD)) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cur_nxt = WADDR_W'(cur_r + 1'b1);
        end
      end
      ST_FIND: begin
        res_push            = 1'b1;
        res_data.free_index = IDX_W'(int'(cur_r) * WORD_BITS + int'(fpos));
        res_data.found      = 1'b1;
        state_nxt           = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        vld_r[cur_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    cls_r   <= cls_nxt;
    blk_r   <= blk_nxt;
    fword_r <= fword_nxt;
    vld_q_r <= vld_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_r] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_empty      = (res_cnt_r == 2'd0);
  assign res_pop        = out_pop && !out_empty;
  assign out_free_index = res_q_r[res_rptr_r].free_index;
  assign out_found      = res_q_r[res_rptr_r].found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wptr_r <= 1'b0;
      res_rptr_r <= 1'b0;
      res_cnt_r  <= 2'd0;
    end else begin
      if (res_push) begin
        res_wptr_r <= ~res_wptr_r;
      end
      if (res_pop) begin
        res_rptr_r <= ~res_rptr_r;
      end
      res_cnt_r <= res_cnt_r + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[res_wptr_r] <= res_data;
    end
  end

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !(res_cnt_r == 2'd2 && !res_pop))
    else $error("result queue overflow");

  a_res_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_find_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIND |-> fword_r != '0)
    else $error("seek entered find with no free bit");

  a_find_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIND |-> (int'(cur_r) * WORD_BITS + int'(fpos)) < MAP_BITS)
    else $error("seek found a block beyond the map");

  a_scan_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !cmd_pop)
    else $error("command taken while another is in progress");

endmodule

[hdl/bitmap_block_allocator_core.sv]
// Top level of the bitmap block allocator: request queue feeding the map sequencer.
// Mark and free read their map word and write it back in a modify state; an unused code is
// answered from idle; a seek scans the map words from word 0 up to the first free bit.
// The sequencer takes one command at a time and holds it until its result is queued;
// it waits while the two-entry result queue is full.
// Synchronous active-low reset empties both queues; per-word valid bits free every block.
module bitmap_block_allocator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [bba_pkg::FUNC_W-1:0] in_func,
  input  logic [bba_pkg::BLK_W-1:0] in_block_number,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [bba_pkg::IDX_W-1:0] out_free_index,
  output logic                      out_found
);
  import bba_pkg::*;

  logic cmd_vld;
  cmd_t cmd;
  logic cmd_pop;

  bba_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_block_number (in_block_number),
    .cmd_vld         (cmd_vld),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  bba_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_vld        (cmd_vld),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_free_index (out_free_index),
    .out_found      (out_found)
  );

endmodule

[tb/bitmap_block_allocator_core_tb.sv]
// Self-checking testbench for the bitmap block allocator: directed, fill and random traffic.
module bitmap_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int FILL_BLOCKS  = 768;
  localparam int RANDOM_ITEMS = 1040;
  localparam int QUIET_TAIL   = 300;

  class usage_map_tracker;
    logic [WORD_BITS-1:0] words [NUM_WORDS];
    res_t pending_results [$];
    int mismatches;

    function new();
      foreach (words[w]) words[w] = '0;
      mismatches = 0;
    endfunction

    function bit lowest_free(output logic [IDX_W-1:0] idx);
      int n;
      idx = '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        if (words[w] == WORD_ONES) continue;
        for (int b = 0; b < WORD_BITS; b++) begin
          n = w * WORD_BITS + b;
          if (n >= MAP_BITS) return 1'b0;
          if (!words[w][WORD_BITS-1-b]) begin
            idx = IDX_W'(n);
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(func_t f, logic [BLK_W-1:0] blk);
      res_t r;
      int w;
      logic [WORD_BITS-1:0] mask;
      r = '0;
      case (f)
        FUNC_MARK, FUNC_FREE: begin
          if (int'(blk) < MAP_BITS) begin
            w    = int'(blk) / WORD_BITS;
            mask = WORD_BITS'(1) << (WORD_BITS - 1 - int'(blk) % WORD_BITS);
            if (f == FUNC_MARK) words[w] |= mask;
            else words[w] &= ~mask;
          end
        end
        FUNC_SEEK: r.found = lowest_free(r.free_index);
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic fnd);
      res_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("Unexpected result: free_index=%0d found=%0b", idx, fnd));
        return;
      end
      e = pending_results.pop_front();
      if (idx !== e.free_index)
        report($sformatf("free_index mismatch: expected %0d, got %0d", e.free_index, idx));
      if (fnd !== e.found)
        report($sformatf("found mismatch: expected %0b, got %0b", e.found, fnd));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [FUNC_W-1:0] in_func = '0;
  logic [BLK_W-1:0]  in_block_number = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [IDX_W-1:0]  out_free_index;
  logic              out_found;

  usage_map_tracker tracker = new();
  bit steady = 1'b0;
  int send_gap_pct = 20;
  int cycles = 0;

  bitmap_block_allocator_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_block_number(in_block_number),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_free_index (out_free_index),
    .out_found      (out_found)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic issue(func_t f, logic [BLK_W-1:0] blk);
    if (!steady && $urandom_range(0, 99) < send_gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_func         <= f;
    in_block_number <= blk;
    do @(posedge clk); while (in_full);
    tracker.note_request(f, blk);
  endtask

  initial begin
    int stall;
    int stall_pct;
    int seen;
    stall = 0;
    stall_pct = 20;
    seen = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        tracker.check_result(out_free_index, out_found);
        seen++;
        if (seen % 100 == 0) stall_pct = $urandom_range(0, 2) * 20;
      end
      if (steady) begin
        out_pop <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall = $urandom_range(1, 6) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [IDX_W-1:0] lowest;
    logic [BLK_W-1:0] blk;
    int base;
    int span;
    int pick;
    func_t f;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(FUNC_SEEK, 12'hFFF);
    issue(FUNC_NOP, 12'hFFF);
    issue(FUNC_MARK, 12'd0);
    issue(FUNC_SEEK, 12'd0);
    issue(FUNC_MARK, 12'd1);
    issue(FUNC_MARK, 12'd2);
    issue(FUNC_SEEK, 12'hAAA);
    issue(FUNC_FREE, 12'd1);
    issue(FUNC_SEEK, 12'h555);
    issue(FUNC_MARK, 12'd4095);
    issue(FUNC_FREE, 12'd4095);
    issue(FUNC_MARK, 12'hAAA);
    issue(FUNC_MARK, 12'h555);
    issue(FUNC_FREE, 12'd0);
    issue(FUNC_SEEK, 12'd0);
    issue(FUNC_FREE, 12'd0);
    issue(FUNC_MARK, 12'd0);
    issue(FUNC_MARK, 12'd0);
    issue(FUNC_NOP, 12'd0);
    issue(FUNC_MARK, 12'd63);
    issue(FUNC_MARK, 12'd64);
    issue(FUNC_SEEK, 12'd0);

    // Fill the low part of the map, then probe seeks that must scan past the filled words.
    for (int n = 0; n < FILL_BLOCKS; n++) begin
      issue(FUNC_MARK, BLK_W'(n));
      if (n % 128 == 127) issue(FUNC_SEEK, BLK_W'($urandom));
    end
    issue(FUNC_SEEK, 12'd0);
    issue(FUNC_NOP, 12'h800);
    issue(FUNC_FREE, 12'd4095);
    issue(FUNC_SEEK, 12'hFFF);
    issue(FUNC_MARK, 12'd4095);
    issue(FUNC_SEEK, 12'd0);
    issue(FUNC_FREE, 12'd64);
    issue(FUNC_FREE, 12'd2047);
    issue(FUNC_SEEK, 12'd0);
    issue(FUNC_FREE, 12'd63);
    issue(FUNC_SEEK, 12'd0);

    // Allocation-like traffic focused on a moving window of the map.
    base = 0;
    span = 64;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) begin
        base = $urandom_range(0, NUM_WORDS - 1) * WORD_BITS;
        span = WORD_BITS << $urandom_range(0, 3);
      end
      if (i % 100 == 0) send_gap_pct = $urandom_range(0, 2) * 15;
      steady = (i >= RANDOM_ITEMS - QUIET_TAIL);
      if ($urandom_range(0, 9) == 0) blk = BLK_W'($urandom);
      else blk = BLK_W'((base + $urandom_range(0, span - 1)) % MAP_BITS);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        f = FUNC_FREE;
      end else if (pick < 65) begin
        f = FUNC_MARK;
        if (pick < 50 && tracker.lowest_free(lowest)) blk = lowest;
      end else if (pick < 97) begin
        f = FUNC_SEEK;
      end else begin
        f = FUNC_NOP;
      end
      issue(f, blk);
    end
    in_push <= 1'b0;
    steady = 1'b1;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
